// File: hw/rtl/brle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brle_pkg
// Shared constants and the command record passed from the front end to the
// back end of the byte run-length encoder.
// ----------------------------------------------------------------------------
package brle_pkg;

  localparam int MAX_RUN_DEF = 128;
  localparam int QDEPTH      = 4;
  localparam int CNT_W       = 8;   // holds any run length up to 128
  localparam int TOT_W       = 18;

  localparam logic [TOT_W-1:0] TOT_MAX  = '1;
  localparam logic [7:0]       REP_BASE = 8'h80;

  // One command per request that produces coded bytes or a store write.
  // A repeat run goes either before the literal run or after it.
  typedef struct packed {
    logic             rep_en;
    logic             rep_first;
    logic [7:0]       rep_hdr;
    logic [7:0]       rep_byte;
    logic             lit_en;
    logic [CNT_W-1:0] lit_len;
    logic             wr_en;
    logic [CNT_W-1:0] wr_idx;
    logic [7:0]       wr_data;
    logic             eos;
  } brle_cmd_t;

endpackage

// File: hw/rtl/brle_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brle_front
// Tracks the open run and turns accepted bytes that write the literal store or
// close a run into encoding commands.
module brle_front import brle_pkg::*; #(
  parameter int MAX_RUN = MAX_RUN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_accept,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_stream,
  output logic       q_push,
  output brle_cmd_t  q_cmd
);

  localparam int LEN_W = $clog2(MAX_RUN + 1);
  localparam logic [LEN_W-1:0] RUN_LIM = LEN_W'(MAX_RUN);

  localparam logic [1:0] RUN_IDLE = 2'd0;
  localparam logic [1:0] RUN_REP  = 2'd1;
  localparam logic [1:0] RUN_LIT  = 2'd2;

  logic [7:0]       held_byte_r, held_byte_nxt;
  logic             held_valid_r, held_valid_nxt;
  logic [1:0]       mode_r, mode_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;

  logic             match;
  logic             flush;
  logic [LEN_W-1:0] base_len;
  logic [LEN_W-1:0] new_len;
  brle_cmd_t        cmd;

  always_comb begin
    cmd            = '0;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    mode_nxt       = mode_r;
    flush          = 1'b0;
    base_len       = len_r;
    new_len        = len_r;
    match          = held_valid_r && (in_byte == held_byte_r);
    cmd.eos        = in_end_of_stream;

    if (match) begin
      // literal of two or more gives up its last byte to the new repeat
      if (mode_r == RUN_LIT && len_r > LEN_W'(1)) begin
        cmd.lit_en  = 1'b1;
        cmd.lit_len = CNT_W'(len_r - LEN_W'(1));
        new_len     = LEN_W'(2);
      end else begin
        new_len = len_r + LEN_W'(1);
      end
      mode_nxt = RUN_REP;
      if (new_len >= RUN_LIM || in_end_of_stream) begin
        cmd.rep_en   = 1'b1;
        cmd.rep_hdr  = REP_BASE + CNT_W'(new_len) - 8'd1;
        cmd.rep_byte = in_byte;
        flush        = 1'b1;
      end
    end else begin
      if (mode_r == RUN_REP) begin
        cmd.rep_en    = 1'b1;
        cmd.rep_first = 1'b1;
        cmd.rep_hdr   = REP_BASE + CNT_W'(len_r) - 8'd1;
        cmd.rep_byte  = held_byte_r;
        base_len      = '0;
      end
      cmd.wr_en      = 1'b1;
      cmd.wr_idx     = CNT_W'(base_len);
      cmd.wr_data    = in_byte;
      new_len        = base_len + LEN_W'(1);
      mode_nxt       = RUN_LIT;
      held_byte_nxt  = in_byte;
      held_valid_nxt = 1'b1;
      if (new_len >= RUN_LIM || in_end_of_stream) begin
        cmd.lit_en  = 1'b1;
        cmd.lit_len = CNT_W'(new_len);
        flush       = 1'b1;
      end
    end

    if (flush) begin
      held_valid_nxt = 1'b0;
      mode_nxt       = RUN_IDLE;
      len_nxt        = '0;
    end else begin
      len_nxt = new_len;
    end
  end

  assign q_cmd  = cmd;
  assign q_push = in_accept && (cmd.wr_en || cmd.rep_en || cmd.lit_en);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      mode_r       <= RUN_IDLE;
      len_r        <= '0;
    end else if (in_accept) begin
      held_valid_r <= held_valid_nxt;
      mode_r       <= mode_nxt;
      len_r        <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      held_byte_r <= held_byte_nxt;
    end
  end

endmodule

// File: hw/rtl/brle_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brle_cmd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module brle_cmd_fifo import brle_pkg::*; #(
  parameter int DEPTH = QDEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  brle_cmd_t wr_cmd,
  input  logic      rd_en,
  output brle_cmd_t rd_cmd,
  output logic      full,
  output logic      empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  brle_cmd_t       entry_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_wr, do_rd;

  assign full   = (count_r == CW'(DEPTH));
  assign empty  = (count_r == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_cmd = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

// File: hw/rtl/brle_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brle_back
// Executes encoding commands: owns the literal store, sequences coded bytes
// one per cycle while the result register can take them, packs them up to four to a result and keeps the running total.
// ----------------------------------------------------------------------------
module brle_back import brle_pkg::*; #(
  parameter int MAX_RUN = MAX_RUN_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  brle_cmd_t        q_cmd,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output logic [31:0]      out_bytes,
  output logic [2:0]       out_count,
  output logic             out_run_end,
  output logic             out_stream_done,
  output logic [TOT_W-1:0] out_total_length
);

  localparam int AW = $clog2(MAX_RUN);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_REP_H = 3'd1;
  localparam logic [2:0] ST_REP_D = 3'd2;
  localparam logic [2:0] ST_LIT_H = 3'd3;
  localparam logic [2:0] ST_LIT_D = 3'd4;

  logic [2:0]       state_r, state_nxt;
  brle_cmd_t        cmd_r;
  logic [CNT_W-1:0] lit_left_r;
  logic [AW-1:0]    rd_idx_r;
  logic [7:0]       rd_data_r;
  logic [7:0]       store_mem [MAX_RUN];

  logic [3:0][7:0]  acc_r;
  logic [1:0]       fill_r;
  logic [TOT_W-1:0] tot_r;

  logic             out_valid_r;
  logic [31:0]      out_bytes_r;
  logic [2:0]       out_count_r;
  logic             out_run_end_r;
  logic             out_done_r;
  logic [TOT_W-1:0] out_total_r;

  logic [7:0]       byte_v;
  logic             last_v;
  logic             byte_vld;
  logic             complete;
  logic             can_take;
  logic             take;
  logic             out_load;
  logic             rd_en;
  logic [31:0]      word_v;
  logic [2:0]       cnt_v;
  logic [TOT_W:0]   sum_v;
  logic [TOT_W-1:0] tot_sat;

  // current coded byte and whether it closes the command
  always_comb begin
    byte_v = '0;
    last_v = 1'b0;
    unique case (state_r)
      ST_REP_H: byte_v = cmd_r.rep_hdr;
      ST_REP_D: begin
        byte_v = cmd_r.rep_byte;
        last_v = !(cmd_r.rep_first && cmd_r.lit_en);
      end
      ST_LIT_H: byte_v = cmd_r.lit_len - 8'd1;
      ST_LIT_D: begin
        byte_v = rd_data_r;
        last_v = (lit_left_r == CNT_W'(1)) && !(cmd_r.rep_en && !cmd_r.rep_first);
      end
      default: ;
    endcase
  end

  assign byte_vld = (state_r != ST_IDLE);
  assign complete = (fill_r == 2'd3) || last_v;
  assign can_take = !complete || !out_valid_r || pop;
  assign take     = byte_vld && can_take;
  assign out_load = take && complete;
  assign rd_en    = take && ((state_r == ST_LIT_H) ||
                             (state_r == ST_LIT_D && lit_left_r > CNT_W'(1)));

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (2'(i) < fill_r) begin
        word_v[31 - 8*i -: 8] = acc_r[i];
      end else if (2'(i) == fill_r) begin
        word_v[31 - 8*i -: 8] = byte_v;
      end else begin
        word_v[31 - 8*i -: 8] = '0;
      end
    end
  end

  assign cnt_v   = {1'b0, fill_r} + 3'd1;
  assign sum_v   = {1'b0, tot_r} + (TOT_W+1)'(cnt_v);
  assign tot_sat = sum_v[TOT_W] ? TOT_MAX : sum_v[TOT_W-1:0];

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_cmd.rep_en && q_cmd.rep_first) begin
            state_nxt = ST_REP_H;
          end else if (q_cmd.lit_en) begin
            state_nxt = ST_LIT_H;
          end else if (q_cmd.rep_en) begin
            state_nxt = ST_REP_H;
          end
        end
      end
      ST_REP_H: if (take) state_nxt = ST_REP_D;
      ST_REP_D: begin
        if (take) begin
          state_nxt = (cmd_r.rep_first && cmd_r.lit_en) ? ST_LIT_H : ST_IDLE;
        end
      end
      ST_LIT_H: if (take) state_nxt = ST_LIT_D;
      ST_LIT_D: begin
        if (take && lit_left_r == CNT_W'(1)) begin
          state_nxt = (cmd_r.rep_en && !cmd_r.rep_first) ? ST_REP_H : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      tot_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
      if (take) begin
        fill_r <= complete ? 2'd0 : fill_r + 2'd1;
      end
      if (out_load) begin
        tot_r <= (last_v && cmd_r.eos) ? '0 : tot_sat;
      end else if (q_pop && q_cmd.eos && !q_cmd.rep_en && !q_cmd.lit_en) begin
        tot_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r    <= q_cmd;
      rd_idx_r <= '0;
    end else if (rd_en) begin
      rd_idx_r <= rd_idx_r + AW'(1);
    end
    if (take && state_r == ST_LIT_H) begin
      lit_left_r <= cmd_r.lit_len;
    end else if (take && state_r == ST_LIT_D) begin
      lit_left_r <= lit_left_r - CNT_W'(1);
    end
    if (take && !complete) begin
      acc_r[fill_r] <= byte_v;
    end
    if (out_load) begin
      out_bytes_r   <= word_v;
      out_count_r   <= cnt_v;
      out_run_end_r <= last_v;
      out_done_r    <= cmd_r.eos;
      out_total_r   <= tot_sat;
    end
  end

  // literal store: written when a command is taken, read ahead of its bytes
  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.wr_en) begin
      store_mem[q_cmd.wr_idx[AW-1:0]] <= q_cmd.wr_data;
    end
    if (rd_en) begin
      rd_data_r <= store_mem[rd_idx_r];
    end
  end

  assign empty            = !out_valid_r;
  assign out_bytes        = out_bytes_r;
  assign out_count        = out_count_r;
  assign out_run_end      = out_run_end_r;
  assign out_stream_done  = out_done_r;
  assign out_total_length = out_total_r;

  // every command ends on a result boundary
  a_idle_no_partial: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (fill_r == 2'd0))
    else $error("partial word left between commands");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || pop))
    else $error("result register overwritten while waiting");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_count_r != 3'd0 && out_count_r <= 3'd4))
    else $error("result byte count out of range");

  a_lit_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LIT_D) |-> (lit_left_r != '0))
    else $error("literal byte counter underflow");

endmodule

// File: hw/rtl/byte_run_length_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_run_length_encoder_unit
// PackBits-style byte run-length encoder with four-byte result packing.
// ----------------------------------------------------------------------------
// Input channel: push / full with in_byte and in_end_of_stream; a request is
// taken on a clock edge with push high and full low. Result channel: empty /
// pop; the oldest result sits on out_* while empty is low and leaves on an
// edge with pop high. The front end accepts one byte per cycle while the
// queue is not full and queues a command whenever a byte writes the literal
// store or closes a run; bytes that only extend a repeat run cost nothing
// downstream. The back end takes a command from the queue while idle and
// then emits one coded byte per cycle while the receiver keeps up; results
// leave every fourth coded byte and on the last one. Sustained input rate is
// one byte per cycle while runs grow, the command queue absorbing short
// flushes.
// Reset clears run state, queue and running total; the literal store needs no
// clearing. A stalled receiver stops the back end, then fills the queue, and
// full rises.
// ----------------------------------------------------------------------------
module byte_run_length_encoder_unit import brle_pkg::*; #(
  parameter int MAX_RUN     = MAX_RUN_DEF,
  parameter int QUEUE_DEPTH = QDEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       in_byte,
  input  logic             in_end_of_stream,
  output logic             empty,
  input  logic             pop,
  output logic [31:0]      out_bytes,
  output logic [2:0]       out_count,
  output logic             out_run_end,
  output logic             out_stream_done,
  output logic [TOT_W-1:0] out_total_length
);

  logic      q_full;
  logic      q_empty;
  logic      q_push;
  logic      q_pop;
  brle_cmd_t q_wr_cmd;
  brle_cmd_t q_rd_cmd;
  logic      in_accept;

  assign full      = q_full;
  assign in_accept = push && !q_full;

  brle_front #(
    .MAX_RUN (MAX_RUN)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_accept        (in_accept),
    .in_byte          (in_byte),
    .in_end_of_stream (in_end_of_stream),
    .q_push           (q_push),
    .q_cmd            (q_wr_cmd)
  );

  brle_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_push),
    .wr_cmd (q_wr_cmd),
    .rd_en  (q_pop),
    .rd_cmd (q_rd_cmd),
    .full   (q_full),
    .empty  (q_empty)
  );

  brle_back #(
    .MAX_RUN (MAX_RUN)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_cmd            (q_rd_cmd),
    .q_pop            (q_pop),
    .pop              (pop),
    .empty            (empty),
    .out_bytes        (out_bytes),
    .out_count        (out_count),
    .out_run_end      (out_run_end),
    .out_stream_done  (out_stream_done),
    .out_total_length (out_total_length)
  );

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for byte_run_length_encoder_unit. A driver process feeds
// raw bytes from a request queue and a result monitor checks every coded word
// against a PackBits-style encoder kept in step with the accepted requests.
// Covers short directed streams, random run/literal streams with idle bursts,
// receiver back-pressure, and a closing stream sent without idle cycles.
// ----------------------------------------------------------------------------
module tb;
  import brle_pkg::*;

  localparam int MAX_RUN     = MAX_RUN_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 20;

  typedef enum logic [1:0] {
    RUN_NONE    = 2'd0,
    RUN_REPEAT  = 2'd1,
    RUN_LITERAL = 2'd2
  } run_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } raw_req_t;

  typedef struct {
    logic [31:0]      bytes;
    logic [2:0]       count;
    logic             run_end;
    logic             stream_done;
    logic [TOT_W-1:0] total;
  } coded_word_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             push = 1'b0;
  logic             full;
  logic [7:0]       in_byte = 8'h00;
  logic             in_end_of_stream = 1'b0;
  logic             empty;
  logic             pop = 1'b0;
  logic [31:0]      out_bytes;
  logic [2:0]       out_count;
  logic             out_run_end;
  logic             out_stream_done;
  logic [TOT_W-1:0] out_total_length;

  raw_req_t    raw_q[$];
  coded_word_t expected_words[$];
  logic [7:0]  coded_q[$];

  // encoder state
  logic [7:0]       last_byte = 8'h00;
  logic             have_byte = 1'b0;
  run_mode_t        mode = RUN_NONE;
  int               run_len = 0;
  logic [7:0]       lit_buf [MAX_RUN];
  logic [TOT_W-1:0] stream_total = '0;

  bit         in_taken = 1'b0;
  bit         idle_on = 1'b1;
  bit         start_hold = 1'b0;
  int         in_gap = 0;
  int         out_gap = 0;
  int         hold_left = 0;
  int         stall_cycles = 0;
  int         fail_cnt = 0;
  logic [7:0] last_sent = 8'h00;

  byte_run_length_encoder_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_byte          (in_byte),
    .in_end_of_stream (in_end_of_stream),
    .empty            (empty),
    .pop              (pop),
    .out_bytes        (out_bytes),
    .out_count        (out_count),
    .out_run_end      (out_run_end),
    .out_stream_done  (out_stream_done),
    .out_total_length (out_total_length)
  );

  always #5 clk = ~clk;

  task automatic clear_run();
    have_byte = 1'b0;
    mode      = RUN_NONE;
    run_len   = 0;
  endtask

  task automatic emit_repeat(input int n);
    coded_q.push_back(8'(REP_BASE + n - 1));
    coded_q.push_back(last_byte);
    clear_run();
  endtask

  task automatic emit_literal(input int n);
    coded_q.push_back(8'(n - 1));
    for (int i = 0; i < n; i++) coded_q.push_back(lit_buf[i]);
    clear_run();
  endtask

  task automatic flush_run();
    if (mode == RUN_REPEAT) emit_repeat(run_len);
    else if (mode == RUN_LITERAL) emit_literal(run_len);
    else clear_run();
  endtask

  // Advance the encoder by one raw byte and queue the coded words it yields.
  task automatic encode_byte(input logic [7:0] b, input logic eos);
    int          nres;
    int          cnt;
    int          sum;
    coded_word_t w;
    coded_q.delete();
    if (have_byte && b == last_byte) begin
      // literal tail byte moves into the new repeat run
      if (mode == RUN_LITERAL && run_len > 1) begin
        emit_literal(run_len - 1);
        run_len   = 1;
        last_byte = b;
        have_byte = 1'b1;
      end
      mode = RUN_REPEAT;
      run_len++;
    end else begin
      if (mode == RUN_REPEAT) emit_repeat(run_len);
      mode      = RUN_LITERAL;
      last_byte = b;
      have_byte = 1'b1;
      if (run_len < MAX_RUN) lit_buf[run_len] = b;
      run_len++;
    end
    if (run_len >= MAX_RUN) flush_run();
    if (eos && run_len != 0) flush_run();

    nres = (coded_q.size() + 3) / 4;
    for (int k = 0; k < nres; k++) begin
      cnt = coded_q.size() - 4 * k;
      if (cnt > 4) cnt = 4;
      w.bytes = '0;
      for (int j = 0; j < 4; j++) begin
        w.bytes = {w.bytes[23:0], (j < cnt) ? coded_q[4 * k + j] : 8'h00};
      end
      sum = int'(stream_total) + cnt;
      stream_total = (sum > int'(TOT_MAX)) ? TOT_MAX : TOT_W'(sum);
      w.count       = 3'(cnt);
      w.run_end     = (k + 1 == nres);
      w.stream_done = eos;
      w.total       = stream_total;
      expected_words.push_back(w);
    end
    if (eos) begin
      clear_run();
      stream_total = '0;
    end
  endtask

  // ---- request driver ----
  always @(posedge clk) begin
    in_taken = rst_n && push && !full;
    if (in_taken) begin
      encode_byte(in_byte, in_end_of_stream);
      void'(raw_q.pop_front());
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (!(push && !in_taken)) begin
      if (in_gap == 0 && idle_on && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 11);
      if (in_gap > 0) begin
        in_gap--;
        push <= 1'b0;
      end else if (raw_q.size() != 0) begin
        push             <= 1'b1;
        in_byte          <= raw_q[0].data;
        in_end_of_stream <= raw_q[0].eos;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // ---- result side ----
  always @(negedge clk) begin
    if (start_hold) begin
      hold_left  = HOLD_CYCLES;
      start_hold = 1'b0;
    end
    if (out_gap == 0 && idle_on && $urandom_range(0, 9) == 0) out_gap = $urandom_range(1, 11);
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      pop <= 1'b0;
    end else begin
      pop <= rst_n;
    end
  end

  always @(posedge clk) begin
    coded_word_t w;
    if (rst_n && pop && !empty) begin
      if (expected_words.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("tb: unexpected result bytes=%h count=%0d", out_bytes, out_count);
      end else begin
        w = expected_words.pop_front();
        if (out_bytes !== w.bytes || out_count !== w.count || out_run_end !== w.run_end ||
            out_stream_done !== w.stream_done || out_total_length !== w.total) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("tb: mismatch exp %h/%0d/%b/%b/%0d got %h/%0d/%b/%b/%0d",
                     w.bytes, w.count, w.run_end, w.stream_done, w.total,
                     out_bytes, out_count, out_run_end, out_stream_done, out_total_length);
        end
      end
    end
  end

  // ---- watchdog ----
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // ---- stimulus ----
  task automatic send_byte(input logic [7:0] b, input logic eos);
    raw_req_t r;
    while (raw_q.size() >= 64) @(posedge clk);
    r.data = b;
    r.eos  = eos;
    raw_q.push_back(r);
    last_sent = b;
  endtask

  task automatic drain();
    while (raw_q.size() != 0 || expected_words.size() != 0) @(posedge clk);
  endtask

  initial begin
    int         rand_items;
    int         seg_len;
    bit         is_rep;
    bit         eos_seg;
    bit         paused;
    logic [7:0] val;
    logic [7:0] x;
    logic [7:0] y;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: single bytes, short repeats, repeat after literal, 4/5-byte packing
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h02, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h30, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h66, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h03, 1'b1);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hC3, 1'b1);
    drain();

    // random run/literal streams; receiver stalls long at the start
    start_hold = 1'b1;
    rand_items = 0;
    paused     = 1'b0;
    while (rand_items < 250) begin
      is_rep  = 1'($urandom_range(0, 1));
      seg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(126, 130) : $urandom_range(1, 8);
      eos_seg = ($urandom_range(0, 3) == 0);
      idle_on = ($urandom_range(0, 3) != 0);
      if (rand_items >= 120 && !paused) begin
        drain();
        paused = 1'b1;
      end
      val = ($urandom_range(0, 2) == 0) ? last_sent : 8'($urandom);
      for (int i = 0; i < seg_len; i++) begin
        if (!is_rep && i > 0) begin
          do val = 8'($urandom); while (val == last_sent);
        end
        send_byte(val, eos_seg && i == seg_len - 1);
      end
      rand_items += seg_len;
    end
    send_byte(8'($urandom), 1'b1);
    drain();

    // closing stream of x,y,y triples with no idle cycles on either side
    idle_on = 1'b0;
    for (int t = 0; t < 12; t++) begin
      do x = 8'($urandom); while (x == last_sent);
      do y = 8'($urandom); while (y == x);
      send_byte(x, 1'b0);
      send_byte(y, 1'b0);
      send_byte(y, 1'b0);
    end
    send_byte(8'h5A, 1'b1);
    send_byte(8'h11, 1'b0);
    send_byte(8'h11, 1'b1);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && expected_words.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
